/* hw/rtl/dts_pkg.sv */
// Shared types and constants for the DMA transfer splitter.
package dts_pkg;

    localparam int NUM_BUFFERS  = 4;
    localparam int BUFFER_BYTES = 4096;
    localparam int WAIT_DEPTH   = 8;
    localparam int BW           = 2;   // buffer index width
    localparam int WW           = 3;   // wait queue index width

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_RESP  = 2'd1;
    localparam logic [1:0] MODE_ABORT = 2'd2;

    localparam logic [2:0] K_REQ     = 3'd0;
    localparam logic [2:0] K_DONE    = 3'd1;
    localparam logic [2:0] K_DELAY   = 3'd2;
    localparam logic [2:0] K_ABWAIT  = 3'd3;
    localparam logic [2:0] K_NOABORT = 3'd4;
    localparam logic [2:0] K_QFULL   = 3'd5;

    localparam logic [0:0] CFG_BLOCK = 1'd0;
    localparam logic [0:0] CFG_SLOTS = 1'd1;

    // one accepted word handed from front to back
    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] address;
        logic [12:0] length;
        logic        is_write;
        logic        is_remote;
        logic [1:0]  buffer_id;
    } t_cmd;

endpackage

/* hw/rtl/dts_cmd_queue.sv */
// Short command queue between the front and the back part.
module dts_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dts_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output dts_pkg::t_cmd   o_cmd
);
    import dts_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_mem[r_rp];

    // store incoming words
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");
endmodule

/* hw/rtl/dts_engine.sv */
// Back part: buffer table, wait queue and request issue sequencer.
module dts_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dts_pkg::t_cmd   i_cmd,
    input  logic [3:0]      i_log2,
    input  logic [4:0]      i_slots,
    output logic            o_pop,
    output logic            o_strobe,
    output logic [2:0]      o_kind,
    output logic [1:0]      o_out_buffer,
    output logic [47:0]     o_req_address,
    output logic [12:0]     o_req_size,
    output logic [11:0]     o_buf_offset,
    output logic            o_req_write,
    output logic            o_status,
    output logic            o_last
);
    import dts_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_FINISH} t_state;

    t_state      r_state;
    logic [NUM_BUFFERS-1:0] r_busy;
    logic [47:0] r_addr  [NUM_BUFFERS];
    logic [12:0] r_rem   [NUM_BUFFERS];
    logic [4:0]  r_cred  [NUM_BUFFERS];
    logic [11:0] r_fill  [NUM_BUFFERS];
    logic [2:0]  r_flags [NUM_BUFFERS];
    logic [62:0] r_wq    [WAIT_DEPTH];
    logic [3:0]  r_wcnt;
    logic [WW-1:0] r_whead;
    logic [BW-1:0] r_cur;

    // effective register values
    logic [3:0] eff_log2;
    logic [4:0] eff_slots;
    always_comb begin
        eff_log2  = (i_log2 < 4'd3) ? 4'd3 : ((i_log2 > 4'd12) ? 4'd12 : i_log2);
        eff_slots = (i_slots == 5'd0) ? 5'd1 : ((i_slots > 5'd16) ? 5'd16 : i_slots);
    end

    // find lowest free buffer and first local busy buffer
    logic          free_hit, loc_hit;
    logic [BW-1:0] free_b, loc_b;
    always_comb begin
        free_hit = 1'b0; free_b = '0; loc_hit = 1'b0; loc_b = '0;
        for (int i = NUM_BUFFERS-1; i >= 0; i--) begin
            if (!r_busy[i]) begin free_hit = 1'b1; free_b = BW'(i); end
            if (r_busy[i] && !r_flags[i][1]) begin loc_hit = 1'b1; loc_b = BW'(i); end
        end
    end

    // request size for the current buffer
    logic [12:0] room, rsize;
    logic [12:0] bmask;
    always_comb begin
        bmask = 13'((13'd1 << eff_log2) - 13'd1);
        room  = 13'((13'd1 << eff_log2) - {1'b0, r_addr[r_cur][11:0] & bmask[11:0]});
        rsize = (r_rem[r_cur] < room) ? r_rem[r_cur] : room;
    end

    logic [12:0] c_len;
    logic [2:0]  c_flags;
    logic        can_issue, fin_now;
    always_comb begin
        c_len = (i_cmd.length > 13'(BUFFER_BYTES)) ? 13'(BUFFER_BYTES) : i_cmd.length;
        can_issue = (r_cred[r_cur] != 5'd0) && (r_rem[r_cur] != 13'd0);
        fin_now = (r_cred[r_cur] >= eff_slots) &&
                  (r_flags[r_cur][2] || r_rem[r_cur] == 13'd0);
    end

    assign o_pop = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_busy <= '0; r_wcnt <= '0; r_whead <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            o_kind <= K_REQ; o_out_buffer <= '0; o_req_address <= '0;
            o_req_size <= '0; o_buf_offset <= '0; o_req_write <= 1'b0;
            o_status <= 1'b0; o_last <= 1'b0;
            unique case (r_state)
                // classify one word
                S_IDLE: begin
                    if (i_valid) begin
                        unique case (i_cmd.mode)
                            MODE_START: begin
                                if (c_len == 13'd0) begin
                                    o_strobe <= 1'b1; o_kind <= K_DONE; o_last <= 1'b1;
                                    o_out_buffer <= free_b;
                                end else if (free_hit) begin
                                    r_busy[free_b] <= 1'b1;
                                    r_addr[free_b] <= i_cmd.address;
                                    r_rem[free_b]  <= c_len;
                                    r_cred[free_b] <= eff_slots;
                                    r_fill[free_b] <= '0;
                                    r_flags[free_b] <= {1'b0, i_cmd.is_remote, i_cmd.is_write};
                                    r_cur <= free_b; r_state <= S_ISSUE;
                                end else if (r_wcnt < 4'(WAIT_DEPTH)) begin
                                    r_wq[WW'(r_whead + r_wcnt[WW-1:0])] <=
                                        {i_cmd.is_remote, i_cmd.is_write, c_len, i_cmd.address};
                                    r_wcnt <= r_wcnt + 4'd1;
                                    o_strobe <= 1'b1; o_kind <= K_DELAY; o_last <= 1'b1;
                                end else begin
                                    o_strobe <= 1'b1; o_kind <= K_QFULL; o_last <= 1'b1;
                                end
                            end
                            MODE_RESP: begin
                                if (r_busy[i_cmd.buffer_id]) begin
                                    if (r_cred[i_cmd.buffer_id] < eff_slots)
                                        r_cred[i_cmd.buffer_id] <= r_cred[i_cmd.buffer_id] + 5'd1;
                                    r_cur <= i_cmd.buffer_id; r_state <= S_FINISH;
                                end
                            end
                            MODE_ABORT: begin
                                if (!loc_hit) begin
                                    o_strobe <= 1'b1; o_kind <= K_NOABORT; o_last <= 1'b1;
                                end else begin
                                    r_flags[loc_b][2] <= 1'b1;
                                    if (r_cred[loc_b] < eff_slots) begin
                                        o_strobe <= 1'b1; o_kind <= K_ABWAIT;
                                        o_out_buffer <= loc_b; o_last <= 1'b1;
                                    end else begin
                                        r_rem[loc_b] <= '0;
                                        r_cur <= loc_b; r_state <= S_FINISH;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // decide finish, issue or return to idle for the current buffer
                S_FINISH: begin
                    if (fin_now) begin
                        o_strobe <= 1'b1; o_kind <= K_DONE; o_out_buffer <= r_cur;
                        o_status <= r_flags[r_cur][2];
                        if (r_wcnt != 4'd0) begin
                            r_addr[r_cur] <= r_wq[r_whead][47:0];
                            r_rem[r_cur]  <= r_wq[r_whead][60:48];
                            r_cred[r_cur] <= eff_slots;
                            r_fill[r_cur] <= '0;
                            r_flags[r_cur] <= {1'b0, r_wq[r_whead][62:61]};
                            r_whead <= r_whead + WW'(1);
                            r_wcnt <= r_wcnt - 4'd1;
                            r_state <= S_ISSUE;
                        end else begin
                            r_busy[r_cur] <= 1'b0; o_last <= 1'b1; r_state <= S_IDLE;
                        end
                    end else if (!r_flags[r_cur][2] && r_rem[r_cur] != 13'd0) begin
                        r_state <= S_ISSUE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                // issue one request a cycle while credits and remaining bytes last
                S_ISSUE: begin
                    if (can_issue) begin
                        o_strobe <= 1'b1; o_kind <= K_REQ; o_out_buffer <= r_cur;
                        o_req_address <= r_addr[r_cur]; o_req_size <= rsize;
                        o_buf_offset <= r_fill[r_cur]; o_req_write <= r_flags[r_cur][0];
                        r_fill[r_cur] <= r_fill[r_cur] + rsize[11:0];
                        r_addr[r_cur] <= r_addr[r_cur] + 48'(rsize);
                        r_rem[r_cur]  <= r_rem[r_cur] - rsize;
                        r_cred[r_cur] <= r_cred[r_cur] - 5'd1;
                        if (r_cred[r_cur] == 5'd1 || r_rem[r_cur] == rsize) begin
                            o_last <= 1'b1; r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_wcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= 4'(WAIT_DEPTH)) else $error("wait queue overrun");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE) else $error("pop outside idle");
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ISSUE |-> r_busy[r_cur]) else $error("issue on free buffer");
endmodule

/* hw/rtl/dma_transfer_splitter_credits_unit.sv */
// Top level of the DMA transfer splitter with request credits.
// Usage: raise start with a word on the i_ payload ports; it is taken at a rising
// edge at which busy is low. busy is high while the two-entry command queue is
// full. The engine pulls one word at a time from the queue. Results are on the
// o_ ports for one cycle each, marked by o_strobe, with o_last on the final
// result of each word; the receiver cannot stall, so no result is held back.
// Steps, with the engine idle: an accepted word is registered in the command
// queue; the engine answers directly from S_IDLE for a delayed, queue full,
// abort waiting, nothing to abort or zero length done result; a start goes on
// to S_ISSUE for its first request; a finishing response or abort gives its
// done from S_FINISH, and a response that only issues more goes on from
// S_FINISH to S_ISSUE. The engine classifies each word in S_IDLE and takes no
// new word from the queue until it is back there; requests come from S_ISSUE,
// and the results of one word follow back to back.
// Configuration: i_cfg_we writes register i_cfg_index (0 block size log2,
// 1 request slots) at once. Reset (synchronous, low) frees all buffers and
// empties both queues; registers go to 6 and 4.
module dma_transfer_splitter_credits_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [47:0] i_address,
    input  logic [12:0] i_length,
    input  logic        i_is_write,
    input  logic        i_is_remote,
    input  logic [1:0]  i_buffer_id,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_out_buffer,
    output logic [47:0] o_req_address,
    output logic [12:0] o_req_size,
    output logic [11:0] o_buf_offset,
    output logic        o_req_write,
    output logic        o_status,
    output logic        o_last
);
    import dts_pkg::*;

    logic [3:0] r_log2;
    logic [4:0] r_slots;
    t_cmd       cmd_in, cmd_q;
    logic       q_valid, q_full, q_pop, push;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= 4'd6; r_slots <= 5'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLOCK: r_log2  <= i_cfg_data[3:0];
                CFG_SLOTS: r_slots <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = q_full;
    assign push = start && !busy;
    assign cmd_in = '{mode: i_mode, address: i_address, length: i_length,
                      is_write: i_is_write, is_remote: i_is_remote,
                      buffer_id: i_buffer_id};

    dts_cmd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(cmd_in),
        .i_pop(q_pop), .o_valid(q_valid), .o_full(q_full), .o_cmd(cmd_q)
    );

    dts_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(cmd_q),
        .i_log2(r_log2), .i_slots(r_slots), .o_pop(q_pop),
        .o_strobe(o_strobe), .o_kind(o_kind), .o_out_buffer(o_out_buffer),
        .o_req_address(o_req_address), .o_req_size(o_req_size),
        .o_buf_offset(o_buf_offset), .o_req_write(o_req_write),
        .o_status(o_status), .o_last(o_last)
    );
endmodule
